/* rtl/core/jpq_pkg.sv */
// Shared definitions for the job priority queue: table depth, field widths,
// command and status codes, and the structs passed along the cell chains.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package jpq_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PRIO_W      = 16;
	localparam int STAGE_W     = 2;
	localparam int TAG_W       = 32;
	localparam int SEQ_W       = 32;
	localparam int KEY_W       = PRIO_W + STAGE_W + SEQ_W + SLOT_W;

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_POP     = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_IDLE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [PRIO_W-1:0]  priority_v;
		logic [STAGE_W-1:0] stage;
		logic [SEQ_W-1:0]   sequence_v;
		logic [SLOT_W-1:0]  slot;
		logic [TAG_W-1:0]   tag;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_entry_t;

	typedef struct packed {
		logic valid;
		logic [SLOT_W-1:0] slot;
	} slot_entry_t;

	typedef struct packed {
		logic insert;
		logic pop;
		logic clear;
	} job_ctrl_t;

	typedef struct packed {
		logic take;
		logic give;
		logic refill;
	} slot_ctrl_t;

	function automatic logic [KEY_W-1:0] job_key(input job_t j);
		return {j.priority_v, j.stage, j.sequence_v, j.slot};
	endfunction

endpackage

/* rtl/core/jpq_job_cell.sv */
// One cell of the sorted job chain; the chain keeps valid jobs in ascending
// key order from cell zero. Depends on jpq_pkg.
`timescale 1ns / 1ps

module jpq_job_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  jpq_pkg::job_ctrl_t ctrl,
	input  jpq_pkg::job_t      new_job,
	input  jpq_pkg::job_entry_t prev_entry,
	input  logic               prev_gt,
	input  jpq_pkg::job_entry_t next_entry,
	output jpq_pkg::job_entry_t entry,
	output logic               gt
);

	logic                valid_q;
	jpq_pkg::job_t       job_q;
	jpq_pkg::job_entry_t entry_d;
	logic                load;

	assign entry = '{valid: valid_q, job: job_q};
	assign gt = !valid_q || (jpq_pkg::job_key(new_job) < jpq_pkg::job_key(job_q));

	always_comb begin
		entry_d = entry;
		load    = 1'b0;
		if (ctrl.clear) begin
			entry_d.valid = 1'b0;
		end else if (ctrl.pop) begin
			entry_d = next_entry;
			load    = 1'b1;
		end else if (ctrl.insert && gt) begin
			load = 1'b1;
			if (prev_gt) begin
				entry_d = prev_entry;
			end else begin
				entry_d = '{valid: 1'b1, job: new_job};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= entry_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= entry_d.job;
		end
	end

endmodule

/* rtl/core/jpq_slot_cell.sv */
// One cell of the free slot chain; free slot numbers are kept in ascending
// order from cell zero so the head is always the lowest free slot.
// Depends on jpq_pkg.
`timescale 1ns / 1ps

module jpq_slot_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [jpq_pkg::SLOT_W-1:0] index,
	input  jpq_pkg::slot_ctrl_t        ctrl,
	input  logic [jpq_pkg::SLOT_W-1:0] new_slot,
	input  jpq_pkg::slot_entry_t       prev_entry,
	input  logic                       prev_gt,
	input  jpq_pkg::slot_entry_t       next_entry,
	output jpq_pkg::slot_entry_t       entry,
	output logic                       gt
);

	jpq_pkg::slot_entry_t entry_q;

	assign entry = entry_q;
	assign gt = !entry_q.valid || (new_slot < entry_q.slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '{valid: 1'b1, slot: index};
		end else if (ctrl.refill) begin
			entry_q <= '{valid: 1'b1, slot: index};
		end else if (ctrl.take) begin
			entry_q <= next_entry;
		end else if (ctrl.give && gt) begin
			if (prev_gt) begin
				entry_q <= prev_entry;
			end else begin
				entry_q <= '{valid: 1'b1, slot: new_slot};
			end
		end
	end

endmodule

/* rtl/core/job_priority_queue.sv */
// Top level of the job priority queue: command decode, sequence counter,
// output register, and the job and free slot cell chains.
// Depends on jpq_pkg, jpq_job_cell and jpq_slot_cell.
//
// Each input transaction carries one command: enqueue a job, pop the least
// job, clear the table, or the idle code, which only answers. Every command
// produces exactly one result transaction with a status and, for a
// successful pop, the job's priority, stage, tag and sequence stamp.
// Jobs are ordered by priority, then stage, then sequence, then slot, all
// ascending. The jobs sit sorted in a chain of cells: an enqueue compares
// the new key in every cell and shifts the greater ones up by one, a pop
// shifts the whole chain down. A second chain holds the free slot numbers
// in order and supplies the lowest one. A result is registered and is valid
// in the cycle after its command is accepted, and one command is accepted
// per cycle while the result side keeps up.
// When the receiver stalls, the result is held and in_stall rises until
// the result is taken; no command is lost. Reset empties the table, marks
// every slot free and zeroes the sequence counter, with no clearing pass.
`timescale 1ns / 1ps

module job_priority_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic [jpq_pkg::PRIO_W-1:0]  job_priority,
	input  logic [jpq_pkg::STAGE_W-1:0] job_stage,
	input  logic [jpq_pkg::TAG_W-1:0]   job_tag,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [jpq_pkg::PRIO_W-1:0]  out_priority,
	output logic [jpq_pkg::STAGE_W-1:0] out_stage,
	output logic [jpq_pkg::TAG_W-1:0]   out_tag,
	output logic [jpq_pkg::SEQ_W-1:0]   out_sequence
);

	localparam int N = jpq_pkg::TABLE_DEPTH;

	jpq_pkg::job_entry_t  job_entry [N];
	logic                 job_gt    [N];
	jpq_pkg::slot_entry_t slot_entry[N];
	logic                 slot_gt   [N];

	jpq_pkg::job_ctrl_t   job_ctrl;
	jpq_pkg::slot_ctrl_t  slot_ctrl;
	jpq_pkg::job_t        new_job;
	jpq_pkg::job_entry_t  head_job;
	logic [jpq_pkg::SEQ_W-1:0] seq_q;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	jpq_pkg::job_t        result_q;
	jpq_pkg::status_t     status_d;
	jpq_pkg::job_t        result_d;
	logic                 accept;
	logic                 full;
	logic                 empty;
	logic                 do_enq;
	logic                 do_pop;
	logic                 do_clear;

	assign head_job = job_entry[0];
	assign full     = job_entry[N-1].valid;
	assign empty    = !head_job.valid;
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		do_enq   = 1'b0;
		do_pop   = 1'b0;
		do_clear = 1'b0;
		status_d = jpq_pkg::STATUS_OK;
		result_d = '0;
		unique case (jpq_pkg::cmd_t'(cmd))
			jpq_pkg::CMD_ENQUEUE: begin
				do_enq = accept && !full;
				if (full) begin
					status_d = jpq_pkg::STATUS_FULL;
				end
			end
			jpq_pkg::CMD_POP: begin
				do_pop = accept && !empty;
				if (empty) begin
					status_d = jpq_pkg::STATUS_EMPTY;
				end else begin
					result_d = head_job.job;
				end
			end
			jpq_pkg::CMD_CLEAR:   do_clear = accept;
			default:              ;
		endcase
	end

	assign new_job = '{
		priority_v: job_priority,
		stage:      job_stage,
		sequence_v: seq_q + 1'b1,
		slot:       slot_entry[0].slot,
		tag:        job_tag
	};

	assign job_ctrl  = '{insert: do_enq, pop: do_pop, clear: do_clear};
	assign slot_ctrl = '{take: do_enq, give: do_pop, refill: do_clear};

	for (genvar i = 0; i < N; i++) begin : g_chain
		jpq_pkg::job_entry_t  job_prev;
		jpq_pkg::job_entry_t  job_next;
		logic                 job_prev_gt;
		jpq_pkg::slot_entry_t slot_prev;
		jpq_pkg::slot_entry_t slot_next;
		logic                 slot_prev_gt;

		if (i == 0) begin : g_first
			assign job_prev     = '0;
			assign job_prev_gt  = 1'b0;
			assign slot_prev    = '0;
			assign slot_prev_gt = 1'b0;
		end else begin : g_mid
			assign job_prev     = job_entry[i-1];
			assign job_prev_gt  = job_gt[i-1];
			assign slot_prev    = slot_entry[i-1];
			assign slot_prev_gt = slot_gt[i-1];
		end

		if (i == N - 1) begin : g_last
			assign job_next  = '0;
			assign slot_next = '0;
		end else begin : g_inner
			assign job_next  = job_entry[i+1];
			assign slot_next = slot_entry[i+1];
		end

		jpq_job_cell u_job_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (job_ctrl),
			.new_job    (new_job),
			.prev_entry (job_prev),
			.prev_gt    (job_prev_gt),
			.next_entry (job_next),
			.entry      (job_entry[i]),
			.gt         (job_gt[i])
		);

		jpq_slot_cell u_slot_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.index      (jpq_pkg::SLOT_W'(i)),
			.ctrl       (slot_ctrl),
			.new_slot   (head_job.job.slot),
			.prev_entry (slot_prev),
			.prev_gt    (slot_prev_gt),
			.next_entry (slot_next),
			.entry      (slot_entry[i]),
			.gt         (slot_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_enq) begin
				seq_q <= seq_q + 1'b1;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
			status_q <= status_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_priority = result_q.priority_v;
	assign out_stage    = result_q.stage;
	assign out_tag      = result_q.tag;
	assign out_sequence = result_q.sequence_v;

endmodule
